/* rtl/scra_pkg.sv */
// Shared definitions for the SPH continuity rate accumulator.
// Holds default sizes, field widths, command, register and sequencer codes.
// No dependencies.
`default_nettype none

package scra_pkg;

  localparam int unsigned MAX_PARTICLES_DEF = 1024;
  localparam int unsigned VALUE_WIDTH_DEF   = 48;
  localparam int unsigned FRAC_BITS         = 32;
  localparam int unsigned INDEX_WIDTH       = 10;
  localparam int unsigned IN_WIDTH          = 47;
  localparam int unsigned VEC_WIDTH         = 48;
  localparam int unsigned RATE_WIDTH        = 48;

  typedef enum logic [1:0] {
    CMD_LOAD,
    CMD_LOAD_TV,
    CMD_PAIR,
    CMD_READ
  } cmd_e;

  typedef enum logic {
    CFG_USE_TV,
    CFG_WALL_DENS
  } cfg_idx_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_PA,
    S_PB,
    S_REL,
    S_ISSUE,
    S_WAIT,
    S_RA,
    S_WA,
    S_RB,
    S_WB,
    S_RD
  } state_e;

  typedef enum logic [3:0] {
    ST_DOT0,
    ST_DOT1,
    ST_DOT2,
    ST_DIV_A,
    ST_MUL_DA,
    ST_MUL_GA,
    ST_MUL_TA,
    ST_DIV_B,
    ST_MUL_DB,
    ST_MUL_GB,
    ST_MUL_TB
  } step_e;

endpackage

`default_nettype wire

/* rtl/scra_mul.sv */
// Multi-cycle fixed-point multiplier with rounding and saturation.
// Builds the magnitude product from four half-width partial products.
// Depends on scra_pkg.
`default_nettype none

module scra_mul #(
  parameter int unsigned W = scra_pkg::VALUE_WIDTH_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  input  logic signed [W-1:0] a_i,
  input  logic signed [W-1:0] b_i,
  output logic                done_o,
  output logic signed [W-1:0] res_o
);
  import scra_pkg::*;

  localparam int unsigned H  = (W + 1) / 2;
  localparam int unsigned AW = 4 * H;
  localparam int unsigned MW = AW + 1;
  localparam logic [MW-1:0] PMAX = MW'((65'd1 << (W - 1)) - 65'd1);
  localparam logic [MW-1:0] HALF = MW'(65'd1 << (FRAC_BITS - 1));

  logic          busy_q, fin_q, done_q, neg_q;
  logic [1:0]    cnt_q;
  logic [2*H-1:0] ma_q, mb_q;
  logic [AW-1:0] acc_q;
  logic [W-1:0]  res_q;

  logic [W-1:0]   ua, ub;
  logic [H-1:0]   opa, opb;
  logic [2*H-1:0] pp;
  logic [AW-1:0]  term;
  logic [MW-1:0]  rnd, mag, nmag;
  logic [W-1:0]   sat_r;

  always_comb begin
    ua  = a_i[W-1] ? (~a_i + W'(1)) : a_i;
    ub  = b_i[W-1] ? (~b_i + W'(1)) : b_i;
    opa = cnt_q[1] ? ma_q[2*H-1:H] : ma_q[H-1:0];
    opb = cnt_q[0] ? mb_q[2*H-1:H] : mb_q[H-1:0];
    pp  = opa * opb;
    if (cnt_q == 2'd0) begin
      term = AW'(pp);
    end else if (cnt_q == 2'd3) begin
      term = AW'(pp) << (2 * H);
    end else begin
      term = AW'(pp) << H;
    end
    rnd  = MW'(acc_q) + HALF;
    mag  = rnd >> FRAC_BITS;
    nmag = ~mag + MW'(1);
    if (!neg_q) begin
      sat_r = (mag > PMAX) ? PMAX[W-1:0] : mag[W-1:0];
    end else if (mag > PMAX + MW'(1)) begin
      sat_r = {1'b1, {(W-1){1'b0}}};
    end else begin
      sat_r = nmag[W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      fin_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= 2'd0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= 2'd0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 2'd1;
        if (cnt_q == 2'd3) begin
          busy_q <= 1'b0;
          fin_q  <= 1'b1;
        end
      end else if (fin_q) begin
        fin_q  <= 1'b0;
        done_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      ma_q  <= (2*H)'(ua);
      mb_q  <= (2*H)'(ub);
      neg_q <= a_i[W-1] ^ b_i[W-1];
      acc_q <= '0;
    end else if (busy_q) begin
      acc_q <= acc_q + term;
    end else if (fin_q) begin
      res_q <= sat_r;
    end
  end

  assign done_o = done_q;
  assign res_o  = res_q;

endmodule

`default_nettype wire

/* rtl/scra_div.sv */
// Restoring fixed-point divider, one quotient bit per cycle.
// Rounds to nearest, saturates, and maps a non-positive divisor to a limit, or to zero for a zero dividend.
// Depends on scra_pkg.
`default_nettype none

module scra_div #(
  parameter int unsigned W = scra_pkg::VALUE_WIDTH_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  input  logic signed [W-1:0] a_i,
  input  logic signed [W-1:0] b_i,
  output logic                done_o,
  output logic signed [W-1:0] res_o
);
  import scra_pkg::*;

  localparam int unsigned NW = W + FRAC_BITS + 1;
  localparam int unsigned CW = $clog2(NW + 1);
  localparam logic [NW-1:0] PMAX = NW'((65'd1 << (W - 1)) - 65'd1);
  localparam logic [W-1:0] SMAX = PMAX[W-1:0];
  localparam logic [W-1:0] SMIN = {1'b1, {(W-1){1'b0}}};

  logic          busy_q, fin_q, done_q, neg_q;
  logic [CW-1:0] cnt_q;
  logic [W:0]    r_q;
  logic [NW-1:0] n_q, q_q;
  logic [W-1:0]  mb_q, res_q;

  logic [W-1:0]  ua, ub;
  logic          bad_div;
  logic [W:0]    rs;
  logic          ge;
  logic [NW-1:0] nq;
  logic [W-1:0]  sat_r;

  always_comb begin
    ua      = a_i[W-1] ? (~a_i + W'(1)) : a_i;
    ub      = b_i;
    bad_div = b_i[W-1] || (b_i == '0);
    rs      = {r_q[W-1:0], n_q[NW-1]};
    ge      = rs >= {1'b0, mb_q};
    nq      = ~q_q + NW'(1);
    if (!neg_q) begin
      sat_r = (q_q > PMAX) ? SMAX : q_q[W-1:0];
    end else if (q_q > PMAX + NW'(1)) begin
      sat_r = SMIN;
    end else begin
      sat_r = nq[W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      fin_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        if (bad_div) begin
          done_q <= 1'b1;
        end else begin
          busy_q <= 1'b1;
          cnt_q  <= CW'(NW);
        end
      end else if (busy_q) begin
        cnt_q <= cnt_q - CW'(1);
        if (cnt_q == CW'(1)) begin
          busy_q <= 1'b0;
          fin_q  <= 1'b1;
        end
      end else if (fin_q) begin
        fin_q  <= 1'b0;
        done_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      neg_q <= a_i[W-1];
      mb_q  <= ub;
      r_q   <= '0;
      q_q   <= '0;
      n_q   <= NW'({ua, {FRAC_BITS{1'b0}}}) + NW'(ub >> 1);
      if (bad_div) begin
        res_q <= (ua == '0) ? '0 : (a_i[W-1] ? SMIN : SMAX);
      end
    end else if (busy_q) begin
      r_q <= ge ? (rs - {1'b0, mb_q}) : rs;
      q_q <= {q_q[NW-2:0], ge};
      n_q <= n_q << 1;
    end else if (fin_q) begin
      res_q <= sat_r;
    end
  end

  assign done_o = done_q;
  assign res_o  = res_q;

endmodule

`default_nettype wire

/* rtl/sph_continuity_rate_accumulator.sv */
// SPH continuity density-rate accumulator, top level; one item is worked on at a time.
// A load writes its entry as it is accepted; a read waits in S_RD while the result beat stalls.
// A pair, after its beat, runs nine products on the shared multiplier, two quotients on the
// bit-serial divider (which skips the division for a non-positive divisor) and two rate
// read-modify-writes. Reset clears control state and configuration registers only.
// Depends on scra_pkg, scra_mul and scra_div.
`default_nettype none

module sph_continuity_rate_accumulator #(
  parameter int unsigned MAX_PARTICLES = scra_pkg::MAX_PARTICLES_DEF,
  parameter int unsigned VALUE_WIDTH   = scra_pkg::VALUE_WIDTH_DEF
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  cfg_valid_i,
  output logic                                  cfg_ready_o,
  input  scra_pkg::cfg_idx_e                    cfg_index_i,
  input  logic [scra_pkg::IN_WIDTH-1:0]         cfg_data_i,
  input  logic                                  in_valid_i,
  output logic                                  in_stall_o,
  input  scra_pkg::cmd_e                        command_i,
  input  logic [scra_pkg::INDEX_WIDTH-1:0]      index_a_i,
  input  logic [scra_pkg::INDEX_WIDTH-1:0]      index_b_i,
  input  logic                                  is_wall_i,
  input  logic                                  partner_owned_i,
  input  logic [scra_pkg::IN_WIDTH-1:0]         mass_i,
  input  logic [scra_pkg::IN_WIDTH-1:0]         density_i,
  input  logic signed [scra_pkg::VEC_WIDTH-1:0] vec_x_i,
  input  logic signed [scra_pkg::VEC_WIDTH-1:0] vec_y_i,
  input  logic signed [scra_pkg::VEC_WIDTH-1:0] vec_z_i,
  input  logic signed [scra_pkg::VEC_WIDTH-1:0] grad_ab_i,
  input  logic signed [scra_pkg::VEC_WIDTH-1:0] grad_ba_i,
  output logic                                  out_valid_o,
  input  logic                                  out_stall_i,
  output logic [scra_pkg::INDEX_WIDTH-1:0]      particle_index_o,
  output logic signed [scra_pkg::RATE_WIDTH-1:0] density_rate_o
);
  import scra_pkg::*;

  localparam int unsigned W  = VALUE_WIDTH;
  localparam int unsigned AW = (MAX_PARTICLES > 1) ? $clog2(MAX_PARTICLES) : 1;
  localparam int unsigned XW = (AW > INDEX_WIDTH) ? AW : INDEX_WIDTH;
  localparam logic [16:0] NPART = 17'(MAX_PARTICLES);
  localparam logic signed [64:0] VMAX = (65'sd1 <<< (W - 1)) - 65'sd1;
  localparam logic signed [64:0] VMIN = -VMAX - 65'sd1;
  localparam logic signed [64:0] RMAX = (65'sd1 <<< (RATE_WIDTH - 1)) - 65'sd1;
  localparam logic signed [64:0] RMIN = -RMAX - 65'sd1;

  typedef struct packed {
    logic               wall;
    logic [W-1:0]       mass;
    logic [W-1:0]       dens;
    logic [2:0][W-1:0]  v;
  } rec_t;

  typedef struct packed {
    rec_t               rec;
    logic [2:0][W-1:0]  tv;
  } entry_t;

  function automatic logic signed [W-1:0] sat_w(input logic signed [64:0] x);
    logic signed [64:0] y;
    y = (x > VMAX) ? VMAX : ((x < VMIN) ? VMIN : x);
    return y[W-1:0];
  endfunction

  function automatic logic signed [W-1:0] sadd(input logic signed [W-1:0] a,
                                               input logic signed [W-1:0] b);
    return sat_w(65'(a) + 65'(b));
  endfunction

  function automatic logic signed [W-1:0] ssub(input logic signed [W-1:0] a,
                                               input logic signed [W-1:0] b);
    return sat_w(65'(a) - 65'(b));
  endfunction

  function automatic logic [RATE_WIDTH-1:0] to_rate(input logic signed [W-1:0] a);
    logic signed [64:0] x;
    x = 65'(a);
    x = (x > RMAX) ? RMAX : ((x < RMIN) ? RMIN : x);
    return x[RATE_WIDTH-1:0];
  endfunction

  // Memories.
  entry_t            part_mem [MAX_PARTICLES];
  logic [W-1:0]      rate_mem [MAX_PARTICLES];
  entry_t            part_rd_q;
  logic [W-1:0]      rate_rd_q;

  state_e state_q, state_d;
  step_e  st_q, st_d, st_next;

  logic              use_tv_q;
  logic [W-1:0]      wdens_q;
  logic [AW-1:0]     ia_q, ib_q;
  logic              owned_q, rng_q;
  logic [INDEX_WIDTH-1:0] pidx_q;
  logic signed [W-1:0] e_q [3];
  logic signed [W-1:0] rel_q [3];
  logic signed [W-1:0] gab_q, gba_q, da_q, db_q, dot_q, ratio_q, x_q, ta_q, tb_q;
  logic              toa_q, tob_q;
  rec_t              rec_a_q, rec_b_q;
  logic [2:0][W-1:0] tv_a_q, tv_b_q;
  logic              out_valid_q;
  logic [INDEX_WIDTH-1:0] out_idx_q;
  logic [RATE_WIDTH-1:0]  out_rate_q;

  logic [XW-1:0]     xa, xb;
  logic [AW-1:0]     in_addr_a, in_addr_b, rd_addr, rate_waddr;
  logic              in_rng_a, in_rng_b;
  logic              rec_we, tv_we, rate_we, out_load;
  logic [W-1:0]      rate_wd;
  rec_t              rec_wd;
  logic [2:0][W-1:0] vin;
  logic [2:0][W-1:0] va, vb;
  logic              mul_start, div_start, step_div, unit_done;
  logic signed [W-1:0] mul_a, mul_b, div_a, div_b, mul_res, div_res;
  logic              mul_done, div_done;

  assign xa        = XW'(index_a_i);
  assign xb        = XW'(index_b_i);
  assign in_addr_a = xa[AW-1:0];
  assign in_addr_b = xb[AW-1:0];
  assign in_rng_a  = 17'(index_a_i) < NPART;
  assign in_rng_b  = 17'(index_b_i) < NPART;

  always_comb begin
    vin[0]      = sat_w(65'(vec_x_i));
    vin[1]      = sat_w(65'(vec_y_i));
    vin[2]      = sat_w(65'(vec_z_i));
    rec_wd.wall = is_wall_i;
    rec_wd.mass = sat_w($signed({18'b0, mass_i}));
    rec_wd.dens = sat_w($signed({18'b0, density_i}));
    rec_wd.v    = vin;
  end

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      va[k] = (rec_a_q.wall || !use_tv_q) ? rec_a_q.v[k] : tv_a_q[k];
      vb[k] = (rec_b_q.wall || !use_tv_q) ? rec_b_q.v[k] : tv_b_q[k];
    end
  end

  // Sequencer operand selection.
  always_comb begin
    mul_a    = x_q;
    mul_b    = dot_q;
    div_a    = rec_b_q.mass;
    div_b    = db_q;
    step_div = 1'b0;
    st_next  = ST_DOT0;
    case (st_q)
      ST_DOT0: begin
        mul_a = e_q[0]; mul_b = rel_q[0]; st_next = ST_DOT1;
      end
      ST_DOT1: begin
        mul_a = e_q[1]; mul_b = rel_q[1]; st_next = ST_DOT2;
      end
      ST_DOT2: begin
        mul_a = e_q[2]; mul_b = rel_q[2]; st_next = ST_DIV_A;
      end
      ST_DIV_A: begin
        step_div = 1'b1; st_next = ST_MUL_DA;
      end
      ST_MUL_DA: begin
        mul_a = da_q; mul_b = ratio_q; st_next = ST_MUL_GA;
      end
      ST_MUL_GA: begin
        mul_b = gab_q; st_next = ST_MUL_TA;
      end
      ST_MUL_TA: begin
        st_next = ST_DIV_B;
      end
      ST_DIV_B: begin
        step_div = 1'b1; div_a = rec_a_q.mass; div_b = da_q; st_next = ST_MUL_DB;
      end
      ST_MUL_DB: begin
        mul_a = db_q; mul_b = ratio_q; st_next = ST_MUL_GB;
      end
      ST_MUL_GB: begin
        mul_b = gba_q; st_next = ST_MUL_TB;
      end
      ST_MUL_TB: begin
        st_next = ST_DOT0;
      end
      default: begin
        st_next = ST_DOT0;
      end
    endcase
    unit_done = step_div ? div_done : mul_done;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      st_q    <= ST_DOT0;
    end else begin
      state_q <= state_d;
      st_q    <= st_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    st_d       = st_q;
    in_stall_o = 1'b1;
    rd_addr    = ia_q;
    rate_waddr = ia_q;
    rate_wd    = '0;
    rec_we     = 1'b0;
    tv_we      = 1'b0;
    rate_we    = 1'b0;
    mul_start  = 1'b0;
    div_start  = 1'b0;
    out_load   = 1'b0;
    case (state_q)
      S_IDLE: begin
        in_stall_o = 1'b0;
        rd_addr    = in_addr_a;
        rate_waddr = in_addr_a;
        if (in_valid_i) begin
          case (command_i)
            CMD_LOAD: begin
              rec_we  = in_rng_a;
              rate_we = in_rng_a;
            end
            CMD_LOAD_TV: begin
              tv_we = in_rng_a;
            end
            CMD_PAIR: begin
              if (in_rng_a && in_rng_b) begin
                state_d = S_PA;
              end
            end
            CMD_READ: begin
              state_d = S_RD;
            end
            default: begin
              state_d = S_IDLE;
            end
          endcase
        end
      end
      S_PA: begin
        rd_addr = ib_q;
        state_d = S_PB;
      end
      S_PB: begin
        state_d = S_REL;
      end
      S_REL: begin
        st_d    = ST_DOT0;
        state_d = S_ISSUE;
      end
      S_ISSUE: begin
        div_start = step_div;
        mul_start = !step_div;
        state_d   = S_WAIT;
      end
      S_WAIT: begin
        if (unit_done) begin
          if (st_q == ST_MUL_TB) begin
            state_d = S_RA;
          end else begin
            st_d    = st_next;
            state_d = S_ISSUE;
          end
        end
      end
      S_RA: begin
        state_d = S_WA;
      end
      S_WA: begin
        rate_wd = sadd(rate_rd_q, ta_q);
        rate_we = toa_q;
        state_d = S_RB;
      end
      S_RB: begin
        rd_addr = ib_q;
        state_d = S_WB;
      end
      S_WB: begin
        rd_addr    = ib_q;
        rate_waddr = ib_q;
        rate_wd    = sadd(rate_rd_q, tb_q);
        rate_we    = tob_q;
        state_d    = S_IDLE;
      end
      S_RD: begin
        if (!out_valid_q || !out_stall_i) begin
          out_load = 1'b1;
          state_d  = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (rec_we) begin
      part_mem[in_addr_a].rec <= rec_wd;
    end
    if (tv_we) begin
      part_mem[in_addr_a].tv <= vin;
    end
    part_rd_q <= part_mem[rd_addr];
  end

  always_ff @(posedge clk_i) begin
    if (rate_we) begin
      rate_mem[rate_waddr] <= rate_wd;
    end
    rate_rd_q <= rate_mem[rd_addr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      use_tv_q <= 1'b0;
      wdens_q  <= '0;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_USE_TV:    use_tv_q <= cfg_data_i[0];
        CFG_WALL_DENS: wdens_q  <= sat_w($signed({18'b0, cfg_data_i}));
        default:       use_tv_q <= use_tv_q;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == S_IDLE && in_valid_i) begin
      ia_q    <= in_addr_a;
      ib_q    <= in_addr_b;
      owned_q <= partner_owned_i;
      rng_q   <= in_rng_a;
      pidx_q  <= index_a_i;
      for (int k = 0; k < 3; k++) begin
        e_q[k] <= vin[k];
      end
      gab_q <= sat_w(65'(grad_ab_i));
      gba_q <= sat_w(65'(grad_ba_i));
    end
    if (state_q == S_PA) begin
      rec_a_q <= part_rd_q.rec;
      tv_a_q  <= part_rd_q.tv;
    end
    if (state_q == S_PB) begin
      rec_b_q <= part_rd_q.rec;
      tv_b_q  <= part_rd_q.tv;
    end
    if (state_q == S_REL) begin
      for (int k = 0; k < 3; k++) begin
        rel_q[k] <= ssub(va[k], vb[k]);
      end
      da_q  <= rec_a_q.wall ? wdens_q : rec_a_q.dens;
      db_q  <= rec_b_q.wall ? wdens_q : rec_b_q.dens;
      toa_q <= !rec_a_q.wall;
      tob_q <= !rec_b_q.wall && owned_q;
    end
    if (state_q == S_WAIT && unit_done) begin
      case (st_q)
        ST_DOT0:   dot_q   <= mul_res;
        ST_DOT1:   dot_q   <= sadd(dot_q, mul_res);
        ST_DOT2:   dot_q   <= sadd(dot_q, mul_res);
        ST_DIV_A:  ratio_q <= div_res;
        ST_DIV_B:  ratio_q <= div_res;
        ST_MUL_TA: ta_q    <= mul_res;
        ST_MUL_TB: tb_q    <= mul_res;
        default:   x_q     <= mul_res;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_idx_q  <= pidx_q;
      out_rate_q <= rng_q ? to_rate(rate_rd_q) : '0;
    end
  end

  scra_mul #(
    .W(W)
  ) u_mul (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(mul_start),
    .a_i    (mul_a),
    .b_i    (mul_b),
    .done_o (mul_done),
    .res_o  (mul_res)
  );

  scra_div #(
    .W(W)
  ) u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(div_start),
    .a_i    (div_a),
    .b_i    (div_b),
    .done_o (div_done),
    .res_o  (div_res)
  );

  assign cfg_ready_o      = 1'b1;
  assign out_valid_o      = out_valid_q;
  assign particle_index_o = out_idx_q;
  assign density_rate_o   = out_rate_q;

endmodule

`default_nettype wire
